// ----- hdl/onewire_temp_sensor_master_core_defines.svh -----
// Assertion helpers shared by the one-wire master RTL.
// Both expect clk and rst_n in scope at the point of use.
`ifndef ONEWIRE_TEMP_SENSOR_MASTER_CORE_DEFINES_SVH
`define ONEWIRE_TEMP_SENSOR_MASTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define ONEWT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define ONEWT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ONEWT_ASSERT_SAME(label, ante, cons, msg)
`define ONEWT_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- hdl/onewt_pkg.sv -----
`default_nettype none

package onewt_pkg;

  localparam int ROM_BITS  = 64;
  localparam int ROM_BYTES = ROM_BITS / 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_SAMPLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_RECOVERY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_LOW       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_HOLD      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_INTERVAL   = 3'd7;

  // Register defaults
  localparam logic [9:0] RST_RESET_LOW       = 10'd500;
  localparam logic [9:0] RST_PRESENCE_SAMPLE = 10'd100;
  localparam logic [9:0] RST_RESET_RECOVERY  = 10'd500;
  localparam logic [7:0] RST_WRITE_LOW       = 8'd3;
  localparam logic [7:0] RST_WRITE_HOLD      = 8'd57;
  localparam logic [7:0] RST_READ_SAMPLE     = 8'd10;
  localparam logic [7:0] RST_POLL_LIMIT      = 8'd255;
  localparam logic [9:0] RST_POLL_INTERVAL   = 10'd50;

  // Actions
  localparam logic [1:0] ACT_TICK        = 2'd0;
  localparam logic [1:0] ACT_CONVERT_READ = 2'd1;
  localparam logic [1:0] ACT_READ_ONLY   = 2'd2;
  localparam logic [1:0] ACT_CONVERT_ALL = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NO_PRESENCE = 2'd1;
  localparam logic [1:0] ST_TIMEOUT     = 2'd2;

  // Bus commands
  localparam logic [7:0] CMD_MATCH    = 8'h55;
  localparam logic [7:0] CMD_SKIP     = 8'hCC;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_READ_PAD = 8'hBE;

  // Fixed slot timing, in ticks
  localparam logic [9:0] SLOT_GAP_TICKS  = 10'd3;
  localparam logic [9:0] READ_LOW_TICKS  = 10'd2;
  localparam logic [9:0] READ_TAIL_TICKS = 10'd48;
  localparam logic [7:0] POLL_COUNT_MAX  = 8'd255;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_REL,
    PH_RST_REC,
    PH_WR_LOW,
    PH_WR_HOLD,
    PH_WR_GAP,
    PH_RD_LOW,
    PH_RD_WAIT,
    PH_RD_TAIL,
    PH_POLL_WAIT
  } phase_t;

  typedef struct packed {
    logic [9:0] reset_low_ticks;
    logic [9:0] presence_sample_ticks;
    logic [9:0] reset_recovery_ticks;
    logic [7:0] write_low_ticks;
    logic [7:0] write_hold_ticks;
    logic [7:0] read_sample_ticks;
    logic [7:0] poll_limit;
    logic [9:0] poll_interval_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]          action;
    logic [ROM_BITS-1:0] dev_rom;
    logic                line_level;
  } in_item_t;

  typedef struct packed {
    logic               drive_low;
    logic               busy_res;
    logic               done_res;
    logic [1:0]         status;
    logic signed [15:0] temperature;
  } out_item_t;

endpackage

`default_nettype wire

// ----- hdl/onewt_cfg.sv -----
`default_nettype none

module onewt_cfg
  import onewt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wen,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wen) begin
      case (cfg_index)
        CFG_RESET_LOW:       cfg_nxt.reset_low_ticks       = cfg_wdata;
        CFG_PRESENCE_SAMPLE: cfg_nxt.presence_sample_ticks = cfg_wdata;
        CFG_RESET_RECOVERY:  cfg_nxt.reset_recovery_ticks  = cfg_wdata;
        CFG_WRITE_LOW:       cfg_nxt.write_low_ticks       = cfg_wdata[7:0];
        CFG_WRITE_HOLD:      cfg_nxt.write_hold_ticks      = cfg_wdata[7:0];
        CFG_READ_SAMPLE:     cfg_nxt.read_sample_ticks     = cfg_wdata[7:0];
        CFG_POLL_LIMIT:      cfg_nxt.poll_limit            = cfg_wdata[7:0];
        CFG_POLL_INTERVAL:   cfg_nxt.poll_interval_ticks   = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_ticks       <= RST_RESET_LOW;
      cfg_r.presence_sample_ticks <= RST_PRESENCE_SAMPLE;
      cfg_r.reset_recovery_ticks  <= RST_RESET_RECOVERY;
      cfg_r.write_low_ticks       <= RST_WRITE_LOW;
      cfg_r.write_hold_ticks      <= RST_WRITE_HOLD;
      cfg_r.read_sample_ticks     <= RST_READ_SAMPLE;
      cfg_r.poll_limit            <= RST_POLL_LIMIT;
      cfg_r.poll_interval_ticks   <= RST_POLL_INTERVAL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- hdl/onewt_fsm.sv -----
`default_nettype none
`include "onewire_temp_sensor_master_core_defines.svh"

module onewt_fsm
  import onewt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic step_en,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t res
);

  phase_t              phase_r, phase_nxt;
  logic [9:0]          tick_r, tick_nxt;
  logic [2:0]          bit_r, bit_nxt;
  logic [3:0]          byte_r, byte_nxt;
  logic [1:0]          kind_r, kind_nxt;
  logic [ROM_BITS-1:0] rom_r, rom_nxt;
  logic [7:0]          obyte_r, obyte_nxt;
  logic [15:0]         iword_r, iword_nxt;
  logic [7:0]          pcnt_r, pcnt_nxt;
  logic                second_r, second_nxt;
  logic                polling_r, polling_nxt;
  logic                sampled_r, sampled_nxt;

  logic       start;
  phase_t     ph;
  logic       live;
  logic [9:0] len;
  logic [9:0] len_eff;
  logic [9:0] tick_eff;
  logic [9:0] tick_inc;
  logic [3:0] byte_inc;
  logic [3:0] burst_len;
  logic       conv;
  logic [7:0] pcnt_inc;
  logic [7:0] poll_lim;
  logic [3:0] rd_pos;
  logic       drive;
  logic       done;
  logic [1:0] status;
  logic [15:0] temp;

  function automatic logic [7:0] burst_byte(input logic [1:0]          kind,
                                            input logic                is_conv,
                                            input logic [ROM_BITS-1:0] rom,
                                            input logic [3:0]          idx);
    logic [7:0] cmd;
    logic [2:0] sel;
    cmd = is_conv ? CMD_CONVERT : CMD_READ_PAD;
    sel = idx[2:0] - 3'd1;
    if (kind == ACT_CONVERT_ALL) begin
      burst_byte = (idx == 4'd0) ? CMD_SKIP : cmd;
    end else if (idx == 4'd0) begin
      burst_byte = CMD_MATCH;
    end else if (idx <= 4'(ROM_BYTES)) begin
      burst_byte = rom[{sel, 3'b000} +: 8];
    end else begin
      burst_byte = cmd;
    end
  endfunction

  always_comb begin
    start       = (phase_r == PH_IDLE) && (item.action != ACT_TICK);
    ph          = start ? PH_RST_LOW : phase_r;
    tick_eff    = start ? '0 : tick_r;
    kind_nxt    = start ? item.action : kind_r;
    rom_nxt     = start ? item.dev_rom : rom_r;
    second_nxt  = start ? 1'b0 : second_r;
    polling_nxt = start ? 1'b0 : polling_r;
    phase_nxt   = ph;
    tick_nxt    = tick_eff;
    bit_nxt     = bit_r;
    byte_nxt    = byte_r;
    obyte_nxt   = obyte_r;
    iword_nxt   = iword_r;
    pcnt_nxt    = pcnt_r;
    sampled_nxt = sampled_r;
    drive       = 1'b0;
    done        = 1'b0;
    status      = ST_OK;
    temp        = '0;
    len         = 10'd1;
    live        = 1'b1;

    conv      = (kind_nxt == ACT_CONVERT_ALL) || ((kind_nxt == ACT_CONVERT_READ) && !second_nxt);
    burst_len = (kind_nxt == ACT_CONVERT_ALL) ? 4'd2 : 4'(ROM_BYTES + 2);
    byte_inc  = byte_r + 4'd1;
    rd_pos    = {byte_r[0], bit_r};
    pcnt_inc  = (pcnt_r < POLL_COUNT_MAX) ? pcnt_r + 8'd1 : pcnt_r;
    poll_lim  = (cfg.poll_limit == 8'd0) ? 8'd1 : cfg.poll_limit;

    // Per-tick drive, duration and sampling
    case (ph)
      PH_IDLE: live = 1'b0;
      PH_RST_LOW: begin
        drive = 1'b1;
        len   = cfg.reset_low_ticks;
      end
      PH_RST_REL: len = cfg.presence_sample_ticks;
      PH_RST_REC: begin
        len = cfg.reset_recovery_ticks;
        if (tick_eff == 10'd0) sampled_nxt = item.line_level;
      end
      PH_WR_LOW: begin
        drive = 1'b1;
        len   = {2'b00, cfg.write_low_ticks};
      end
      PH_WR_HOLD: begin
        drive = ~obyte_r[bit_r];
        len   = {2'b00, cfg.write_hold_ticks};
      end
      PH_WR_GAP: len = SLOT_GAP_TICKS;
      PH_RD_LOW: begin
        drive = 1'b1;
        len   = READ_LOW_TICKS;
      end
      PH_RD_WAIT: len = {2'b00, cfg.read_sample_ticks};
      PH_RD_TAIL: begin
        len = READ_TAIL_TICKS;
        if (tick_eff == 10'd0) begin
          sampled_nxt = item.line_level;
          if (!polling_nxt && item.line_level) iword_nxt[rd_pos] = 1'b1;
        end
      end
      PH_POLL_WAIT: len = cfg.poll_interval_ticks;
      default: begin
        live      = 1'b0;
        phase_nxt = PH_IDLE;
      end
    endcase

    len_eff  = (len == 10'd0) ? 10'd1 : len;
    tick_inc = tick_eff + 10'd1;

    if (live) begin
      if (tick_inc >= len_eff) begin
        tick_nxt = '0;
        // Phase finished: advance the sequence
        case (ph)
          PH_RST_LOW: phase_nxt = PH_RST_REL;
          PH_RST_REL: phase_nxt = PH_RST_REC;
          PH_RST_REC: begin
            if (sampled_nxt) begin
              phase_nxt = PH_IDLE;
              done      = 1'b1;
              status    = ST_NO_PRESENCE;
            end else begin
              byte_nxt  = '0;
              bit_nxt   = '0;
              obyte_nxt = burst_byte(kind_nxt, conv, rom_nxt, 4'd0);
              phase_nxt = PH_WR_LOW;
            end
          end
          PH_WR_LOW:  phase_nxt = PH_WR_HOLD;
          PH_WR_HOLD: phase_nxt = PH_WR_GAP;
          PH_WR_GAP: begin
            if (bit_r != 3'd7) begin
              bit_nxt   = bit_r + 3'd1;
              phase_nxt = PH_WR_LOW;
            end else begin
              bit_nxt  = '0;
              byte_nxt = byte_inc;
              if (byte_inc < burst_len) begin
                obyte_nxt = burst_byte(kind_nxt, conv, rom_nxt, byte_inc);
                phase_nxt = PH_WR_LOW;
              end else if (conv) begin
                polling_nxt = 1'b1;
                pcnt_nxt    = '0;
                phase_nxt   = PH_RD_LOW;
              end else begin
                polling_nxt = 1'b0;
                byte_nxt    = '0;
                iword_nxt   = '0;
                phase_nxt   = PH_RD_LOW;
              end
            end
          end
          PH_RD_LOW:  phase_nxt = PH_RD_WAIT;
          PH_RD_WAIT: phase_nxt = PH_RD_TAIL;
          PH_RD_TAIL: begin
            if (polling_nxt) begin
              if (sampled_nxt) begin
                polling_nxt = 1'b0;
                if (kind_nxt == ACT_CONVERT_READ) begin
                  second_nxt = 1'b1;
                  phase_nxt  = PH_RST_LOW;
                end else begin
                  phase_nxt = PH_IDLE;
                  done      = 1'b1;
                end
              end else begin
                pcnt_nxt = pcnt_inc;
                if (pcnt_inc >= poll_lim) begin
                  phase_nxt = PH_IDLE;
                  done      = 1'b1;
                  status    = ST_TIMEOUT;
                end else begin
                  phase_nxt = PH_POLL_WAIT;
                end
              end
            end else if (bit_r != 3'd7) begin
              bit_nxt   = bit_r + 3'd1;
              phase_nxt = PH_RD_LOW;
            end else begin
              bit_nxt  = '0;
              byte_nxt = byte_inc;
              if (byte_inc < 4'd2) begin
                phase_nxt = PH_RD_LOW;
              end else begin
                phase_nxt = PH_IDLE;
                done      = 1'b1;
                temp      = iword_nxt;
              end
            end
          end
          PH_POLL_WAIT: phase_nxt = PH_RD_LOW;
          default:      phase_nxt = PH_IDLE;
        endcase
      end else begin
        tick_nxt = tick_inc;
      end
    end

    res.drive_low   = drive;
    res.busy_res    = (phase_nxt != PH_IDLE);
    res.done_res    = done;
    res.status      = status;
    res.temperature = $signed(temp);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      tick_r    <= '0;
      bit_r     <= '0;
      byte_r    <= '0;
      kind_r    <= '0;
      rom_r     <= '0;
      obyte_r   <= '0;
      iword_r   <= '0;
      pcnt_r    <= '0;
      second_r  <= 1'b0;
      polling_r <= 1'b0;
      sampled_r <= 1'b0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      bit_r     <= bit_nxt;
      byte_r    <= byte_nxt;
      kind_r    <= kind_nxt;
      rom_r     <= rom_nxt;
      obyte_r   <= obyte_nxt;
      iword_r   <= iword_nxt;
      pcnt_r    <= pcnt_nxt;
      second_r  <= second_nxt;
      polling_r <= polling_nxt;
      sampled_r <= sampled_nxt;
    end
  end

  `ONEWT_ASSERT_SAME(a_idle_tick_clear, phase_r == PH_IDLE, tick_r == 10'd0, "tick count left non-zero while idle")
  `ONEWT_ASSERT_NEXT(a_done_goes_idle, step_en && res.done_res, phase_r == PH_IDLE, "sequencer not idle after done")

endmodule

`default_nettype wire

// ----- hdl/onewire_temp_sensor_master_core.sv -----
// Each input beat yields exactly one result beat, via the input and result registers.
// Throughput: one tick beat per cycle while the result register is not stalled.
// The bus sequencer advances by one tick whenever a beat leaves the input register.
// Reset (rst_n low, synchronous): sequencer idle, registers at their defaults,
// no beats held in either register.
`default_nettype none
`include "onewire_temp_sensor_master_core_defines.svh"

module onewire_temp_sensor_master_core
  import onewt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  in_item_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_wen,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_data_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  logic      move;
  logic      in_take;
  cfg_t      cfg;
  out_item_t res;

  onewt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  onewt_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (move),
    .item    (s1_data_r),
    .cfg     (cfg),
    .res     (res)
  );

  // Advance the held beat whenever the result register is free or draining
  assign move     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !move;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (move) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (move) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_data_r <= in_data;
    if (move) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ONEWT_ASSERT_SAME(a_done_not_busy, out_valid_r && out_data_r.done_res, !out_data_r.busy_res, "done beat still flagged busy")
  `ONEWT_ASSERT_SAME(a_fault_no_temp, out_valid_r && (out_data_r.status != ST_OK), out_data_r.temperature == 16'sd0, "temperature set on a faulted beat")
  `ONEWT_ASSERT_SAME(a_free_out_no_stall, !out_valid_r, !in_stall, "input stalled with empty result register")

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import onewt_pkg::*;

  typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_PERIODIC} flow_t;

  localparam int JOB_TICK_CAP = 100_000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  onewire_temp_sensor_master_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Register shadow and sequencer copy
  cfg_t        reg_shadow = '{RST_RESET_LOW, RST_PRESENCE_SAMPLE, RST_RESET_RECOVERY,
                              RST_WRITE_LOW, RST_WRITE_HOLD, RST_READ_SAMPLE,
                              RST_POLL_LIMIT, RST_POLL_INTERVAL};
  phase_t      seq_phase = PH_IDLE;
  logic [9:0]  tick_cnt = '0;
  logic [2:0]  bit_idx = '0;
  logic [3:0]  byte_idx = '0;
  logic [1:0]  job_kind = ACT_TICK;
  logic [63:0] rom_hold = '0;
  logic [7:0]  tx_byte = '0;
  logic [15:0] rx_word = '0;
  logic [7:0]  polls = '0;
  logic        second_pass = 1'b0;
  logic        polling_now = 1'b0;
  logic        line_seen = 1'b0;
  logic        fin_done;
  logic [1:0]  fin_status;
  logic [15:0] fin_temp;

  out_item_t   predicted_bus_outputs [$];
  int          fault_count = 0;

  // Behaviour of the simulated sensor on the bus
  logic        pres_first = 1'b1;
  logic        pres_second = 1'b1;
  int          done_pct = 50;
  logic [15:0] temp_plan = '0;
  int          req_pct = 15;

  int          sender_burst_left = 0;
  bit          holdoff_req = 1'b0;
  int          holdoff_left = 0;
  flow_t       flow_mode = FLOW_FREE;
  int          flow_left = 0;

  initial forever #6 clk = ~clk;

  function automatic int floor1(input int v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic bit convert_burst();
    return job_kind == ACT_CONVERT_ALL || (job_kind == ACT_CONVERT_READ && !second_pass);
  endfunction

  function automatic logic [7:0] burst_byte(input logic [3:0] idx);
    logic [7:0] cmd;
    cmd = convert_burst() ? CMD_CONVERT : CMD_READ_PAD;
    if (job_kind == ACT_CONVERT_ALL) return (idx == 0) ? CMD_SKIP : cmd;
    if (idx == 0) return CMD_MATCH;
    if (idx <= ROM_BYTES) return rom_hold[8 * ((idx - 1) & 7) +: 8];
    return cmd;
  endfunction

  function automatic void conclude(input logic [1:0] st, input logic [15:0] t);
    seq_phase = PH_IDLE;
    fin_done = 1'b1;
    fin_status = st;
    fin_temp = t;
  endfunction

  // One microsecond tick of the bus master
  task automatic bus_master_tick(input in_item_t it, output out_item_t res);
    int len;
    logic drive;
    drive = 1'b0;
    len = 1;
    fin_done = 1'b0;
    fin_status = ST_OK;
    fin_temp = '0;
    if (seq_phase == PH_IDLE && it.action != ACT_TICK) begin
      rom_hold = it.dev_rom;
      job_kind = it.action;
      second_pass = 1'b0;
      polling_now = 1'b0;
      seq_phase = PH_RST_LOW;
      tick_cnt = '0;
    end
    if (seq_phase != PH_IDLE) begin
      case (seq_phase)
        PH_RST_LOW: begin
          drive = 1'b1;
          len = int'(reg_shadow.reset_low_ticks);
        end
        PH_RST_REL: len = int'(reg_shadow.presence_sample_ticks);
        PH_RST_REC: begin
          len = int'(reg_shadow.reset_recovery_ticks);
          if (tick_cnt == 0) line_seen = it.line_level;
        end
        PH_WR_LOW: begin
          drive = 1'b1;
          len = int'(reg_shadow.write_low_ticks);
        end
        PH_WR_HOLD: begin
          drive = ~tx_byte[bit_idx];
          len = int'(reg_shadow.write_hold_ticks);
        end
        PH_WR_GAP: len = int'(SLOT_GAP_TICKS);
        PH_RD_LOW: begin
          drive = 1'b1;
          len = int'(READ_LOW_TICKS);
        end
        PH_RD_WAIT: len = int'(reg_shadow.read_sample_ticks);
        PH_RD_TAIL: begin
          len = int'(READ_TAIL_TICKS);
          if (tick_cnt == 0) begin
            line_seen = it.line_level;
            if (!polling_now && it.line_level) rx_word[{byte_idx[0], bit_idx}] = 1'b1;
          end
        end
        PH_POLL_WAIT: len = int'(reg_shadow.poll_interval_ticks);
        default: ;
      endcase
      len = floor1(len);
      if (int'(tick_cnt) + 1 >= len) begin
        tick_cnt = '0;
        case (seq_phase)
          PH_RST_LOW: seq_phase = PH_RST_REL;
          PH_RST_REL: seq_phase = PH_RST_REC;
          PH_RST_REC: begin
            if (line_seen) begin
              conclude(ST_NO_PRESENCE, '0);
            end else begin
              byte_idx = '0;
              bit_idx = '0;
              tx_byte = burst_byte('0);
              seq_phase = PH_WR_LOW;
            end
          end
          PH_WR_LOW: seq_phase = PH_WR_HOLD;
          PH_WR_HOLD: seq_phase = PH_WR_GAP;
          PH_WR_GAP: begin
            if (bit_idx < 7) begin
              bit_idx++;
              seq_phase = PH_WR_LOW;
            end else begin
              bit_idx = '0;
              byte_idx++;
              if (byte_idx < ((job_kind == ACT_CONVERT_ALL) ? 2 : ROM_BYTES + 2)) begin
                tx_byte = burst_byte(byte_idx);
                seq_phase = PH_WR_LOW;
              end else if (convert_burst()) begin
                polling_now = 1'b1;
                polls = '0;
                seq_phase = PH_RD_LOW;
              end else begin
                polling_now = 1'b0;
                byte_idx = '0;
                bit_idx = '0;
                rx_word = '0;
                seq_phase = PH_RD_LOW;
              end
            end
          end
          PH_RD_LOW: seq_phase = PH_RD_WAIT;
          PH_RD_WAIT: seq_phase = PH_RD_TAIL;
          PH_RD_TAIL: begin
            if (polling_now) begin
              if (line_seen) begin
                polling_now = 1'b0;
                if (job_kind == ACT_CONVERT_READ) begin
                  // convert finished: go round again for the scratchpad read
                  second_pass = 1'b1;
                  seq_phase = PH_RST_LOW;
                  tick_cnt = '0;
                end else begin
                  conclude(ST_OK, '0);
                end
              end else begin
                if (polls < POLL_COUNT_MAX) polls++;
                if (int'(polls) >= floor1(int'(reg_shadow.poll_limit)))
                  conclude(ST_TIMEOUT, '0);
                else seq_phase = PH_POLL_WAIT;
              end
            end else if (bit_idx < 7) begin
              bit_idx++;
              seq_phase = PH_RD_LOW;
            end else begin
              bit_idx = '0;
              byte_idx++;
              if (byte_idx < 2) seq_phase = PH_RD_LOW;
              else conclude(ST_OK, rx_word);
            end
          end
          PH_POLL_WAIT: seq_phase = PH_RD_LOW;
          default: seq_phase = PH_IDLE;
        endcase
      end else begin
        tick_cnt++;
      end
    end
    res.drive_low = drive;
    res.busy_res = (seq_phase != PH_IDLE);
    res.done_res = fin_done;
    res.status = fin_status;
    res.temperature = fin_temp;
  endtask

  // Line level the sensor presents on the next tick
  function automatic logic sensor_line();
    if (seq_phase == PH_RST_REC && tick_cnt == 0)
      return second_pass ? !pres_second : !pres_first;
    if (seq_phase == PH_RD_TAIL && tick_cnt == 0) begin
      if (polling_now) return $urandom_range(99) < done_pct;
      return temp_plan[{byte_idx[0], bit_idx}];
    end
    return 1'($urandom_range(1));
  endfunction

  task automatic send_tick(input in_item_t it);
    out_item_t want;
    int gap;
    if (sender_burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      sender_burst_left = ($urandom_range(3) == 0) ? $urandom_range(200, 800)
                                                    : $urandom_range(1, 40);
    end
    sender_burst_left--;
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    bus_master_tick(it, want);
    predicted_bus_outputs.push_back(want);
  endtask

  task automatic send_idle_ticks(input int n);
    in_item_t it;
    repeat (n) begin
      it.action = ACT_TICK;
      it.dev_rom = {$urandom, $urandom};
      it.line_level = 1'($urandom_range(1));
      send_tick(it);
    end
  endtask

  // Send the start tick of one transaction
  task automatic start_job(input logic [1:0] kind);
    in_item_t it;
    it.action = kind;
    it.dev_rom = {$urandom, $urandom};
    it.line_level = sensor_line();
    send_tick(it);
  endtask

  // Feed sensor ticks while the sequencer is busy, at most n of them
  task automatic busy_ticks(input int n);
    in_item_t it;
    int k;
    k = 0;
    while (seq_phase != PH_IDLE && k < n) begin
      it.action = ($urandom_range(99) < req_pct) ?
                  2'($urandom_range(ACT_CONVERT_READ, ACT_CONVERT_ALL)) : ACT_TICK;
      it.dev_rom = {$urandom, $urandom};
      it.line_level = sensor_line();
      send_tick(it);
      k++;
    end
  endtask

  // Start one transaction and clock it through to its done beat
  task automatic run_transaction(input logic [1:0] kind);
    start_job(kind);
    busy_ticks(JOB_TICK_CAP);
  endtask

  // Hold the sender until every predicted beat has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (predicted_bus_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_RESET_LOW:       reg_shadow.reset_low_ticks = val;
      CFG_PRESENCE_SAMPLE: reg_shadow.presence_sample_ticks = val;
      CFG_RESET_RECOVERY:  reg_shadow.reset_recovery_ticks = val;
      CFG_WRITE_LOW:       reg_shadow.write_low_ticks = val[7:0];
      CFG_WRITE_HOLD:      reg_shadow.write_hold_ticks = val[7:0];
      CFG_READ_SAMPLE:     reg_shadow.read_sample_ticks = val[7:0];
      CFG_POLL_LIMIT:      reg_shadow.poll_limit = val[7:0];
      CFG_POLL_INTERVAL:   reg_shadow.poll_interval_ticks = val;
      default: ;
    endcase
  endtask

  task automatic program_all(input logic [9:0] rl, ps, rr, wl, wh, rs, pl, pi);
    write_reg(CFG_RESET_LOW, rl);
    write_reg(CFG_PRESENCE_SAMPLE, ps);
    write_reg(CFG_RESET_RECOVERY, rr);
    write_reg(CFG_WRITE_LOW, wl);
    write_reg(CFG_WRITE_HOLD, wh);
    write_reg(CFG_READ_SAMPLE, rs);
    write_reg(CFG_POLL_LIMIT, pl);
    write_reg(CFG_POLL_INTERVAL, pi);
  endtask

  // Small value for an 8-bit register, sometimes with junk above bit 7
  function automatic logic [9:0] narrow_reg_value(input int hi);
    return 10'($urandom_range(0, hi)) | (($urandom_range(3) == 0) ? 10'h300 : 10'h000);
  endfunction

  task automatic test_reset_defaults();
    pres_first = 1'b1;
    pres_second = 1'b1;
    done_pct = 100;
    req_pct = 10;
    send_idle_ticks(6);
    // reset pulse under the default timing; left running for the next test
    start_job(ACT_CONVERT_ALL);
    busy_ticks(24);
  endtask

  task automatic test_zero_durations();
    drain();
    // zero everywhere, poll limit included; the running reset pulse ends at once
    program_all('0, '0, '0, '0, '0, '0, '0, '0);
    busy_ticks(JOB_TICK_CAP);
    send_idle_ticks(3);
  endtask

  task automatic test_no_presence();
    req_pct = 0;
    pres_first = 1'b0;
    run_transaction(ACT_CONVERT_READ);
    run_transaction(ACT_READ_ONLY);
    run_transaction(ACT_CONVERT_ALL);
    pres_first = 1'b1;
    req_pct = 15;
  endtask

  task automatic test_ignored_requests();
    // a request on every busy tick, the done tick included
    req_pct = 100;
    pres_first = 1'b0;
    run_transaction(ACT_READ_ONLY);
    run_transaction(ACT_CONVERT_ALL);
    run_transaction(ACT_CONVERT_READ);
    pres_first = 1'b1;
    req_pct = 15;
  endtask

  task automatic test_poll_timeout();
    drain();
    // junk above bit 7 only: the limit reads as zero and counts as one
    write_reg(CFG_POLL_LIMIT, 10'h300);
    done_pct = 0;
    run_transaction(ACT_CONVERT_ALL);
    done_pct = 100;
  endtask

  task automatic test_extreme_timing();
    drain();
    program_all(10'd1023, 10'd1023, 10'd1023, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'd1023);
    pres_first = 1'b0;
    start_job(ACT_CONVERT_READ);
    busy_ticks(12);
    drain();
    program_all('0, '0, '0, '0, '0, '0, '0, '0);
    busy_ticks(JOB_TICK_CAP);
    pres_first = 1'b1;
  endtask

  task automatic test_backpressure();
    drain();
    holdoff_req = 1'b1;
    send_idle_ticks(40);
    drain();
    send_idle_ticks(10);
  endtask

  task automatic test_random_jobs();
    for (int ph = 0; ph < 3; ph++) begin
      drain();
      program_all(10'($urandom_range(0, 3)), 10'($urandom_range(0, 3)),
                  10'($urandom_range(0, 3)), narrow_reg_value(5), narrow_reg_value(5),
                  narrow_reg_value(5), narrow_reg_value(4), 10'($urandom_range(0, 10)));
      for (int j = 0; j < 4; j++) begin
        pres_first = 1'b0;
        req_pct = int'($urandom_range(0, 40));
        run_transaction(2'($urandom_range(ACT_CONVERT_READ, ACT_CONVERT_ALL)));
        send_idle_ticks(int'($urandom_range(0, 4)));
      end
    end
    pres_first = 1'b1;
  endtask

  // Result side: stall pattern, with a long hold-off on request
  always @(posedge clk) begin
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else if (holdoff_req) begin
      holdoff_req = 1'b0;
      holdoff_left = 299;
      out_stall <= 1'b1;
    end else begin
      if (flow_left == 0) begin
        flow_mode = flow_t'($urandom_range(FLOW_FREE, FLOW_PERIODIC));
        flow_left = $urandom_range(20, 300);
      end else begin
        flow_left--;
      end
      case (flow_mode)
        FLOW_FREE:  out_stall <= 1'b0;
        FLOW_LIGHT: out_stall <= $urandom_range(99) < 25;
        FLOW_HEAVY: out_stall <= $urandom_range(99) < 60;
        default:    out_stall <= (flow_left % 3 == 0);
      endcase
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_bus_outputs.size() == 0) begin
        $error("result beat with no prediction waiting");
        fault_count++;
      end else begin
        want = predicted_bus_outputs.pop_front();
        if (out_data.drive_low !== want.drive_low) begin
          $error("drive_low: expected %0d, got %0d", want.drive_low, out_data.drive_low);
          fault_count++;
        end
        if (out_data.busy_res !== want.busy_res) begin
          $error("busy_res: expected %0d, got %0d", want.busy_res, out_data.busy_res);
          fault_count++;
        end
        if (out_data.done_res !== want.done_res) begin
          $error("done_res: expected %0d, got %0d", want.done_res, out_data.done_res);
          fault_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          fault_count++;
        end
        if (out_data.temperature !== want.temperature) begin
          $error("temperature: expected %0d, got %0d", want.temperature,
                 out_data.temperature);
          fault_count++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_zero_durations();
    test_no_presence();
    test_ignored_requests();
    test_poll_timeout();
    test_extreme_timing();
    test_backpressure();
    test_random_jobs();
    drain();
    repeat (10) @(posedge clk);
    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/onewt_pkg.sv
hdl/onewt_cfg.sv
hdl/onewt_fsm.sv
hdl/onewire_temp_sensor_master_core.sv
tb/tb.sv
